/* rtl/asb_pkg.sv */
// shared constants and control types for the ascending sort buffer
package asb_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 16;

	// controller commands to the cell chain
	typedef struct packed {
		logic load;   // an item enters cell 0 this cycle
		logic shift;  // the chain moves one place toward cell 0
	} chain_ctrl_t;

endpackage

/* rtl/asb_cell.sv */
// one insertion cell: keeps the smaller value, hands the larger one on
module asb_cell #(
	parameter int VALUE_BITS = asb_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift,
	input  logic                         in_vld,
	input  logic signed [VALUE_BITS-1:0] in_val,
	output logic                         pass_vld,
	output logic signed [VALUE_BITS-1:0] pass_val,
	output logic                         held_vld,
	output logic signed [VALUE_BITS-1:0] held_val,
	input  logic                         next_vld,
	input  logic signed [VALUE_BITS-1:0] next_val
);

	logic                         held_vld_q;
	logic signed [VALUE_BITS-1:0] held_val_q;
	logic                         pass_vld_q;
	logic signed [VALUE_BITS-1:0] pass_val_q;
	logic                         take_new;

	// incoming item goes into the cell when empty or smaller than the held one
	assign take_new = !held_vld_q || (in_val < held_val_q);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (shift) begin
			held_vld_q <= next_vld;
			pass_vld_q <= 1'b0;
		end else begin
			if (in_vld) begin
				held_vld_q <= 1'b1;
			end
			pass_vld_q <= in_vld && held_vld_q;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (shift) begin
			held_val_q <= next_val;
		end else if (in_vld) begin
			if (take_new) begin
				held_val_q <= in_val;
				pass_val_q <= held_val_q;
			end else begin
				pass_val_q <= in_val;
			end
		end
	end

	assign pass_vld = pass_vld_q;
	assign pass_val = pass_val_q;
	assign held_vld = held_vld_q;
	assign held_val = held_val_q;

endmodule

/* rtl/asb_ctrl.sv */
// sequencer for load, settle and unload of the cell chain
module asb_ctrl #(
	parameter int DEPTH = asb_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_last,
	output logic                out_overflow,
	input  logic                head_vld,
	output asb_pkg::chain_ctrl_t chain_ctrl
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_LOAD   = 3'b001,
		ST_DRAIN  = 3'b010,
		ST_UNLOAD = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] wait_q;
	logic          dropped_q;
	logic          in_acc;
	logic          out_acc;
	logic          room;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_UNLOAD);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign room      = (cnt_q != CW'(DEPTH));

	assign out_last     = (cnt_q == CW'(1));
	assign out_overflow = dropped_q;

	assign chain_ctrl.load  = in_acc && room;
	assign chain_ctrl.shift = out_acc;

	// state, element count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			wait_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= ST_DRAIN;
							wait_q  <= CW'(DEPTH - 1);
						end
					end
				end
				ST_DRAIN: begin
					// let items in flight reach their cells
					if (wait_q == '0) begin
						state_q <= ST_UNLOAD;
					end else begin
						wait_q <= wait_q - CW'(1);
					end
				end
				ST_UNLOAD: begin
					if (out_acc) begin
						cnt_q <= cnt_q - CW'(1);
						if (out_last) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// checks
	a_out_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != '0) && head_vld)
		else $error("result offered with empty chain");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("load and unload at once");

	a_last_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> (state_q == ST_DRAIN))
		else $error("last item did not start settling");

	a_end_of_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last |=> in_ready && (cnt_q == '0) && !dropped_q)
		else $error("set not closed after final result");

endmodule

/* rtl/ascending_sort_buffer.sv */
// ascending sort buffer: systolic insertion chain with load/unload control
// Load: one item accepted per cycle; each value then moves up the chain to its cell.
// After the last item, the chain settles in the drain state, then one sorted result per
// cycle while out_ready is high. The next set loads after the final result is taken.
// Throughput set by one cell step per cycle.
// Reset (arst_n low) empties every cell and clears count and overflow flag.
module ascending_sort_buffer #(
	parameter int DEPTH      = asb_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = asb_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value_in,
	input  logic                         last_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] value_out,
	output logic                         last_out,
	output logic                         overflow
);

	asb_pkg::chain_ctrl_t chain_ctrl;

	logic                         in_vld   [DEPTH];
	logic signed [VALUE_BITS-1:0] in_val   [DEPTH];
	logic                         pass_vld [DEPTH];
	logic signed [VALUE_BITS-1:0] pass_val [DEPTH];
	logic                         held_vld [DEPTH];
	logic signed [VALUE_BITS-1:0] held_val [DEPTH];
	logic                         next_vld [DEPTH];
	logic signed [VALUE_BITS-1:0] next_val [DEPTH];

	// sequencer
	asb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_last      (last_in),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_last     (last_out),
		.out_overflow (overflow),
		.head_vld     (held_vld[0]),
		.chain_ctrl   (chain_ctrl)
	);

	// chain wiring: items flow up, unload moves down toward cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign in_vld[i] = chain_ctrl.load;
			assign in_val[i] = value_in;
		end else begin : g_body
			assign in_vld[i] = pass_vld[i-1];
			assign in_val[i] = pass_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_vld[i] = 1'b0;
			assign next_val[i] = '0;
		end else begin : g_inner
			assign next_vld[i] = held_vld[i+1];
			assign next_val[i] = held_val[i+1];
		end

		asb_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (chain_ctrl.shift),
			.in_vld   (in_vld[i]),
			.in_val   (in_val[i]),
			.pass_vld (pass_vld[i]),
			.pass_val (pass_val[i]),
			.held_vld (held_vld[i]),
			.held_val (held_val[i]),
			.next_vld (next_vld[i]),
			.next_val (next_val[i])
		);
	end

	// smallest value sits in cell 0
	assign value_out = held_val[0];

endmodule

/* bench/ascending_sort_buffer_test.sv */
// self-checking testbench for the ascending sort buffer with a sorting scoreboard
`timescale 1ns / 1ps

module ascending_sort_buffer_test;

	localparam int SET_DEPTH   = asb_pkg::DEPTH_DEF;
	localparam int VALUE_WIDTH = asb_pkg::VALUE_BITS_DEF;
	localparam int RANDOM_ITEMS = 250;
	localparam int DIRECTED_ITEMS = 25;

	typedef logic signed [VALUE_WIDTH-1:0] fixed_t;

	typedef struct {
		fixed_t value;
		logic   last;
		logic   ovf;
	} sorted_elem_t;

	// collects each set, sorts it on the last item and checks results in order
	class sorted_set_tracker;
		fixed_t       set_values[$];
		bit           set_dropped;
		sorted_elem_t sorted_due[$];
		int           failures;

		function new();
			set_dropped = 1'b0;
			failures = 0;
		endfunction

		function void take_element(fixed_t value, logic last);
			fixed_t       ordered[$];
			fixed_t       x;
			sorted_elem_t e;
			int           j;
			if (set_values.size() < SET_DEPTH) begin
				set_values.push_back(value);
			end else begin
				set_dropped = 1'b1;
			end
			if (!last) return;
			// insertion sort by signed value
			ordered = set_values;
			for (int i = 1; i < ordered.size(); i++) begin
				x = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > x) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = x;
			end
			foreach (ordered[i]) begin
				e.value = ordered[i];
				e.last  = (i == ordered.size() - 1);
				e.ovf   = set_dropped;
				sorted_due.push_back(e);
			end
			set_values.delete();
			set_dropped = 1'b0;
		endfunction

		function void match_result(fixed_t value, logic last, logic ovf);
			sorted_elem_t e;
			if (sorted_due.size() == 0) begin
				$error("unexpected result: value_out=%0d last_out=%0b overflow=%0b",
					value, last, ovf);
				failures++;
				return;
			end
			e = sorted_due.pop_front();
			if (value !== e.value) begin
				$error("value_out: expected %0d, got %0d", e.value, value);
				failures++;
			end
			if (last !== e.last) begin
				$error("last_out: expected %0b, got %0b", e.last, last);
				failures++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow: expected %0b, got %0b", e.ovf, ovf);
				failures++;
			end
		endfunction

		function int outstanding();
			return sorted_due.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	fixed_t value_in = '0;
	logic   last_in = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	fixed_t value_out;
	logic   last_out;
	logic   overflow;

	sorted_set_tracker tracker;
	bit steady_phase = 1'b0;
	int items_sent = 0;

	// directed: single element, extremes, duplicates, sorted and reversed runs
	fixed_t directed_vals [DIRECTED_ITEMS] = '{
		16'sh7FFF,
		16'sh0000, 16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1, 16'sd256, -16'sd256,
		16'sh5555, 16'shAAAA,
		16'sd3, -16'sd3, 16'sd3, 16'sd3, 16'sh8000, 16'sh8000,
		-16'sd2, -16'sd1, 16'sd0, 16'sd1, 16'sd2,
		16'sd100, 16'sd50, -16'sd50, -16'sd100
	};
	bit directed_last [DIRECTED_ITEMS] = '{
		1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1
	};

	ascending_sort_buffer #(
		.DEPTH(SET_DEPTH),
		.VALUE_BITS(VALUE_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value_in(value_in),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_out(value_out),
		.last_out(last_out),
		.overflow(overflow)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("ascending_sort_buffer_test: FAIL");
		$finish;
	end

	// watch both handshakes on the edge
	always @(posedge clk) begin
		if (arst_n && tracker != null) begin
			if (in_valid && in_ready) tracker.take_element(value_in, last_in);
			if (out_valid && out_ready) tracker.match_result(value_out, last_out, overflow);
		end
	end

	// offer one item after a random gap (none in the steady phase) and hold it until taken
	task automatic send_item(input fixed_t value, input logic last);
		int gap;
		gap = steady_phase ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= value;
		last_in  <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// mostly random values, with extremes and small values for duplicates
	function automatic fixed_t pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return fixed_t'($urandom_range(0, 7)) - fixed_t'(4);
			default: return fixed_t'($urandom());
		endcase
	endfunction

	task automatic send_set(input int size);
		for (int i = 0; i < size; i++) send_item(pick_value(), i == size - 1);
	endtask

	// result side: random stall before each item (none in the steady phase), held ready until taken
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_phase ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		int set_index;
		int size;
		int start_count;

		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ITEMS; i++) send_item(directed_vals[i], directed_last[i]);

		// random sets: mostly short, some full, some past the store depth
		set_index = 0;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			steady_phase = ($urandom_range(0, 3) == 0);
			if (set_index == 2) begin
				size = SET_DEPTH + 1;
			end else if (set_index == 5) begin
				size = SET_DEPTH;
			end else begin
				case ($urandom_range(0, 9))
					0: size = SET_DEPTH + $urandom_range(1, 4);
					1: size = SET_DEPTH - $urandom_range(0, 1);
					default: size = $urandom_range(1, 10);
				endcase
			end
			send_set(size);
			set_index++;
		end
		in_valid <= 1'b0;
		steady_phase = 1'b0;

		// let the monitor note the final item, drain, then watch for stray results
		@(posedge clk);
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (SET_DEPTH + 16) @(posedge clk);

		if (tracker.failures == 0) begin
			$display("ascending_sort_buffer_test: PASS");
		end else begin
			$display("ascending_sort_buffer_test: FAIL");
		end
		$finish;
	end

endmodule
